// ===== rtl/acc_pkg.sv =====
// Shared types, widths and codes for the alpha coverage classifier.
// No dependencies; imported by every module of the block.
package acc_pkg;

  localparam int unsigned MaxPixels     = 16384;
  localparam int unsigned CountW        = 15;
  localparam int unsigned CountCap      = (MaxPixels < 32767) ? MaxPixels : 32767;
  localparam int unsigned ChanW         = 8;
  localparam int unsigned ShareW        = 10;
  localparam int unsigned ProdW         = CountW + ShareW;
  localparam int unsigned PermilleScale = 1000;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 10;
  localparam int unsigned InDataW       = 4 * ChanW;
  localparam int unsigned OutDataW      = 48;

  typedef enum logic [1:0] {
    VERDICT_ART    = 2'd0,
    VERDICT_OPAQUE = 2'd1,
    VERDICT_WHITE  = 2'd2
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLEAR_ALPHA  = 3'd0,
    CFG_WHITE_MIN    = 3'd1,
    CFG_WHITE_SPREAD = 3'd2,
    CFG_CLEAR_SHARE  = 3'd3,
    CFG_WHITE_SHARE  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0]  clear_alpha;
    logic [ChanW-1:0]  white_min;
    logic [ChanW-1:0]  white_spread;
    logic [ShareW-1:0] clear_share;
    logic [ShareW-1:0] white_share;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] opacity;
    logic             last;
  } pixel_t;

  typedef struct packed {
    logic clear;
    logic white;
    logic last;
  } pix_class_t;

  typedef struct packed {
    logic [CountW-1:0] pixels;
    logic [CountW-1:0] clear;
    logic [CountW-1:0] white;
  } counts_t;

endpackage

// ===== rtl/acc_classify.sv =====
// Per-pixel classification: transparent, or painted and near white.
// Depends on acc_pkg.
module acc_classify
  import acc_pkg::*;
(
  input  pixel_t     pixel_i,
  input  cfg_t       cfg_i,
  output pix_class_t class_o
);

  logic [ChanW-1:0] lo_rg, hi_rg, lo, hi, spread;

  always_comb begin
    lo_rg  = (pixel_i.red < pixel_i.green) ? pixel_i.red : pixel_i.green;
    hi_rg  = (pixel_i.red > pixel_i.green) ? pixel_i.red : pixel_i.green;
    lo     = (lo_rg < pixel_i.blue) ? lo_rg : pixel_i.blue;
    hi     = (hi_rg > pixel_i.blue) ? hi_rg : pixel_i.blue;
    spread = hi - lo;

    class_o.clear = pixel_i.opacity < cfg_i.clear_alpha;
    class_o.white = !class_o.clear && (lo >= cfg_i.white_min) &&
                    (spread <= cfg_i.white_spread);
    class_o.last  = pixel_i.last;
  end

endmodule

// ===== rtl/acc_count.sv =====
// Saturating image counters and the end-of-image snapshot register.
// Depends on acc_pkg.
module acc_count
  import acc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  pix_class_t class_i,
  output logic       snap_ready_o,
  output logic       snap_valid_o,
  input  logic       snap_take_i,
  output counts_t    snap_o
);

  counts_t cnt_q, cnt_d, bumped;
  counts_t snap_q;
  logic    snap_valid_q, snap_valid_d;

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] cnt);
    return (cnt < CountW'(CountCap)) ? cnt + CountW'(1) : cnt;
  endfunction

  always_comb begin
    bumped.pixels = bump(cnt_q.pixels);
    bumped.clear  = class_i.clear ? bump(cnt_q.clear) : cnt_q.clear;
    bumped.white  = class_i.white ? bump(cnt_q.white) : cnt_q.white;

    cnt_d = cnt_q;
    if (take_i) begin
      cnt_d = class_i.last ? '0 : bumped;
    end

    snap_valid_d = snap_valid_q;
    if (take_i && class_i.last) begin
      snap_valid_d = 1'b1;
    end else if (snap_take_i) begin
      snap_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && class_i.last) begin
      snap_q <= bumped;
    end
  end

  assign snap_ready_o = !snap_valid_q || snap_take_i;
  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  // counters restart from zero once an image closes
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && class_i.last |=> cnt_q == '0)
    else $error("counters not cleared after final pixel");

endmodule

// ===== rtl/acc_verdict.sv =====
// Verdict pipeline: share products, then compares into the result register.
// Depends on acc_pkg.
module acc_verdict
  import acc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  counts_t           counts_i,
  input  logic [ShareW-1:0] clear_share_i,
  input  logic [ShareW-1:0] white_share_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output verdict_e          verdict_o,
  output counts_t           counts_o
);

  // product stage
  logic [ProdW-1:0] clr_scaled_q, clr_limit_q, wht_scaled_q, wht_limit_q;
  logic [ProdW-1:0] clr_scaled_d, clr_limit_d, wht_scaled_d, wht_limit_d;
  logic             painted_nz_q, painted_nz_d;
  counts_t          prod_cnt_q;
  logic             prod_valid_q;

  // result stage
  verdict_e         verdict_q, verdict_d;
  counts_t          out_cnt_q;
  logic             out_valid_q;

  logic [CountW-1:0] painted;
  logic              out_ready, prod_ready, prod_load, out_load;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign prod_ready = !prod_valid_q || out_ready;
  assign prod_load  = in_valid_i && prod_ready;
  assign out_load   = prod_valid_q && out_ready;
  assign in_ready_o = prod_ready;

  always_comb begin
    painted      = (counts_i.pixels >= counts_i.clear) ?
                   counts_i.pixels - counts_i.clear : '0;
    painted_nz_d = painted != '0;
    clr_scaled_d = ProdW'(counts_i.clear) * ProdW'(PermilleScale);
    clr_limit_d  = ProdW'(clear_share_i) * ProdW'(counts_i.pixels);
    wht_scaled_d = ProdW'(counts_i.white) * ProdW'(PermilleScale);
    wht_limit_d  = ProdW'(white_share_i) * ProdW'(painted);
  end

  always_comb begin
    if (clr_scaled_q < clr_limit_q) begin
      verdict_d = VERDICT_OPAQUE;
    end else if (painted_nz_q && (wht_scaled_q >= wht_limit_q)) begin
      verdict_d = VERDICT_WHITE;
    end else begin
      verdict_d = VERDICT_ART;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_load) begin
      clr_scaled_q <= clr_scaled_d;
      clr_limit_q  <= clr_limit_d;
      wht_scaled_q <= wht_scaled_d;
      wht_limit_q  <= wht_limit_d;
      painted_nz_q <= painted_nz_d;
      prod_cnt_q   <= counts_i;
    end
    if (out_load) begin
      verdict_q <= verdict_d;
      out_cnt_q <= prod_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign counts_o    = out_cnt_q;

endmodule

// ===== rtl/alpha_coverage_classifier_top.sv =====
// Alpha coverage classifier top level: pixel input register, config
// registers and the count and verdict stages. Depends on acc_pkg and all acc_* modules.
//
//   channel  | direction | handshake                    | payload
//   s_axis   | in        | s_axis_tvalid/s_axis_tready  | RGBA pixel, tlast = final pixel
//   m_axis   | out       | m_axis_tvalid/m_axis_tready  | verdict and image totals
//   cfg      | in        | cfg_we_i (always taken)      | cfg_addr_i, cfg_wdata_i
//
// One pixel per cycle sustained while no final pixel waits for the snapshot
// register; every stage is a register with a valid bit. A final pixel's result
// reaches the output through the input register, count snapshot, product
// register and result register. Stalls on m_axis back up stage by stage; pixels
// keep flowing while the result register holds a verdict. Reset clears counters
// and valid bits and loads the default thresholds; no clearing pass is needed.
module alpha_coverage_classifier_top
  import acc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // red, green, blue, opacity
  input  logic                s_axis_tlast,   // final pixel of the image
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // verdict, clear_total, white_total,
                                              // pixel_total, zero pad
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  pixel_t     pix_q;
  logic       pix_valid_q;
  pix_class_t pix_class;
  logic       snap_ready, snap_valid, snap_take, pix_adv, in_take;
  counts_t    snap_cnt, out_cnt;
  verdict_e   verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clear_alpha  <= ChanW'(8);
      cfg_q.white_min    <= ChanW'(200);
      cfg_q.white_spread <= ChanW'(40);
      cfg_q.clear_share  <= ShareW'(50);
      cfg_q.white_share  <= ShareW'(900);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_CLEAR_ALPHA:  cfg_q.clear_alpha  <= cfg_wdata_i[ChanW-1:0];
        CFG_WHITE_MIN:    cfg_q.white_min    <= cfg_wdata_i[ChanW-1:0];
        CFG_WHITE_SPREAD: cfg_q.white_spread <= cfg_wdata_i[ChanW-1:0];
        CFG_CLEAR_SHARE:  cfg_q.clear_share  <= cfg_wdata_i[ShareW-1:0];
        CFG_WHITE_SHARE:  cfg_q.white_share  <= cfg_wdata_i[ShareW-1:0];
        default: ;
      endcase
    end
  end

  // a final pixel waits here until the snapshot register is free
  assign pix_adv       = pix_valid_q && (!pix_q.last || snap_ready);
  assign s_axis_tready = !pix_valid_q || pix_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      pix_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pix_q.red     <= s_axis_tdata[ChanW-1:0];
      pix_q.green   <= s_axis_tdata[2*ChanW-1:ChanW];
      pix_q.blue    <= s_axis_tdata[3*ChanW-1:2*ChanW];
      pix_q.opacity <= s_axis_tdata[4*ChanW-1:3*ChanW];
      pix_q.last    <= s_axis_tlast;
    end
  end

  acc_classify u_classify (
    .pixel_i (pix_q),
    .cfg_i   (cfg_q),
    .class_o (pix_class)
  );

  acc_count u_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (pix_adv),
    .class_i      (pix_class),
    .snap_ready_o (snap_ready),
    .snap_valid_o (snap_valid),
    .snap_take_i  (snap_take),
    .snap_o       (snap_cnt)
  );

  logic verdict_ready;
  assign snap_take = snap_valid && verdict_ready;

  acc_verdict u_verdict (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (snap_valid),
    .in_ready_o    (verdict_ready),
    .counts_i      (snap_cnt),
    .clear_share_i (cfg_q.clear_share),
    .white_share_i (cfg_q.white_share),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .verdict_o     (verdict),
    .counts_o      (out_cnt)
  );

  assign m_axis_tdata = {1'b0, out_cnt.pixels, out_cnt.white, out_cnt.clear, verdict};

  a_pixels_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_cnt.pixels != '0)
    else $error("result with no pixels counted");

  a_clear_le_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_cnt.clear <= out_cnt.pixels)
    else $error("transparent count exceeds pixel count");

  a_pixels_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_cnt.pixels <= CountW'(CountCap))
    else $error("pixel count beyond saturation limit");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (verdict == VERDICT_WHITE) |-> out_cnt.pixels != out_cnt.clear)
    else $error("white verdict without painted pixels");

endmodule
